// ===== rtl/core/bmm_pkg.sv =====
// Shared types and codes for the banked memory map bus.
package bmm_pkg;

	// Bus access kinds; the reserved code behaves as a read
	typedef enum logic [1:0] {
		OP_READ  = 2'd0,
		OP_WRITE = 2'd1,
		OP_LOAD  = 2'd2,
		OP_RSVD  = 2'd3
	} op_t;

	// Access status codes
	localparam logic [2:0] ST_OK       = 3'd0;
	localparam logic [2:0] ST_UNMAPPED = 3'd1;
	localparam logic [2:0] ST_BADBANK  = 3'd2;
	localparam logic [2:0] ST_LOCKED   = 3'd3;
	localparam logic [2:0] ST_ROMWRITE = 3'd4;

	// Configuration register indexes (byte address is 4 * index)
	localparam logic [2:0] REG_ROM_SEL    = 3'd0;
	localparam logic [2:0] REG_ROM_COUNT  = 3'd1;
	localparam logic [2:0] REG_RAM_SEL    = 3'd2;
	localparam logic [2:0] REG_RAM_COUNT  = 3'd3;
	localparam logic [2:0] REG_VRAM_LOCK  = 3'd4;
	localparam logic [2:0] REG_OAM_LOCK   = 3'd5;

	// Region sizes of the machine map
	localparam int ROM_BANK_SIZE = 16384;
	localparam int RAM_BANK_SIZE = 8192;
	localparam int SMALL_SIZE    = 512;

	typedef struct packed {
		op_t         op;
		logic [15:0] bus_address;
		logic [7:0]  write_data;
		logic        from_video;
	} req_t;

	typedef struct packed {
		logic [7:0] read_data;
		logic [2:0] status;
	} rsp_t;

	typedef struct packed {
		logic [7:0] rom_bank_select;
		logic [3:0] rom_bank_count;
		logic [3:0] ram_bank_select;
		logic [2:0] ram_bank_count;
		logic       video_ram_locked;
		logic       sprite_table_locked;
	} cfg_t;

	// Decoded access control handed to the storage side
	typedef struct packed {
		logic       ram_en;
		logic       rom_en;
		logic       we;
		logic [2:0] status;
	} dec_t;

endpackage

// ===== rtl/core/bmm_decode.sv =====
// Address decoder: folds the echo window and maps an access onto RAM or ROM storage.
module bmm_decode
	import bmm_pkg::*;
#(
	parameter int MAX_ROM_BANKS = 8,
	parameter int MAX_RAM_BANKS = 4,
	localparam int ROM_DEPTH = (MAX_ROM_BANKS + 1) * ROM_BANK_SIZE,
	localparam int ROM_AW = $clog2(ROM_DEPTH),
	localparam int EXT_SIZE = MAX_RAM_BANKS * RAM_BANK_SIZE,
	localparam int RAM_DEPTH = EXT_SIZE + 2 * RAM_BANK_SIZE + SMALL_SIZE,
	localparam int RAM_AW = $clog2(RAM_DEPTH)
) (
	input  req_t              req,
	input  cfg_t              cfg,
	output dec_t              ctl,
	output logic [RAM_AW-1:0] ram_addr,
	output logic [ROM_AW-1:0] rom_addr
);

	localparam int VRAM_BASE  = EXT_SIZE;
	localparam int WRAM_BASE  = EXT_SIZE + RAM_BANK_SIZE;
	localparam int SMALL_BASE = EXT_SIZE + 2 * RAM_BANK_SIZE;

	logic [15:0] fa;
	logic        wr;
	logic        rom_bad;
	logic        ram_bad;
	logic [8:0]  rom_bank_p1;
	logic [8:0]  soff;

	// Echo fold and bank checks
	always_comb begin
		fa = req.bus_address;
		if (req.bus_address >= 16'hE000 && req.bus_address <= 16'hFDFF)
			fa = req.bus_address - 16'h2000;
		wr = (req.op == OP_WRITE) || (req.op == OP_LOAD);
		rom_bad = (cfg.rom_bank_select >= {4'd0, cfg.rom_bank_count}) ||
			({1'b0, cfg.rom_bank_select} >= 9'(MAX_ROM_BANKS));
		ram_bad = ({1'b0, cfg.ram_bank_select} >= {2'b00, cfg.ram_bank_count}) ||
			({1'b0, cfg.ram_bank_select} >= 5'(MAX_RAM_BANKS));
		rom_bank_p1 = {1'b0, cfg.rom_bank_select} + 9'd1;
	end

	// Offset inside the packed block of small regions
	always_comb begin
		if (fa < 16'hFF00)
			soff = {1'b0, fa[7:0]};
		else if (fa < 16'hFF80)
			soff = {2'b10, fa[6:0]};
		else
			soff = {2'b11, fa[6:0]};
	end

	// Region decode
	always_comb begin
		ctl = '0;
		ctl.we = wr;
		ctl.status = ST_OK;
		ram_addr = '0;
		rom_addr = '0;
		if (fa >= 16'hFEA0 && fa <= 16'hFEFF) begin
			ctl.status = ST_UNMAPPED;
		end else if (fa < 16'h4000) begin
			if (req.op == OP_WRITE) begin
				ctl.status = ST_ROMWRITE;
			end else begin
				ctl.rom_en = 1'b1;
				rom_addr = ROM_AW'(fa[13:0]);
			end
		end else if (fa < 16'h8000) begin
			if (req.op == OP_WRITE) begin
				ctl.status = ST_ROMWRITE;
			end else if (rom_bad) begin
				ctl.status = ST_BADBANK;
			end else begin
				ctl.rom_en = 1'b1;
				rom_addr = ROM_AW'({rom_bank_p1, fa[13:0]});
			end
		end else if (fa < 16'hA000) begin
			if (cfg.video_ram_locked && !req.from_video) begin
				ctl.status = ST_LOCKED;
			end else begin
				ctl.ram_en = 1'b1;
				ram_addr = RAM_AW'(VRAM_BASE) + RAM_AW'(fa[12:0]);
			end
		end else if (fa < 16'hC000) begin
			if (ram_bad) begin
				ctl.status = ST_BADBANK;
			end else begin
				ctl.ram_en = 1'b1;
				ram_addr = RAM_AW'({cfg.ram_bank_select, fa[12:0]});
			end
		end else if (fa < 16'hE000) begin
			ctl.ram_en = 1'b1;
			ram_addr = RAM_AW'(WRAM_BASE) + RAM_AW'(fa[12:0]);
		end else if (fa < 16'hFEA0) begin
			// sprite table, the only part left below the hole after folding
			if (cfg.sprite_table_locked && !req.from_video) begin
				ctl.status = ST_LOCKED;
			end else begin
				ctl.ram_en = 1'b1;
				ram_addr = RAM_AW'(SMALL_BASE) + RAM_AW'(soff);
			end
		end else begin
			// I/O registers, high RAM and interrupt enable
			ctl.ram_en = 1'b1;
			ram_addr = RAM_AW'(SMALL_BASE) + RAM_AW'(soff);
		end
	end

endmodule

// ===== rtl/core/banked_memory_map_bus.sv =====
// Banked memory map bus: decode, RAM and ROM storage, config registers and response stage.
//
// Requests arrive on req/req_valid/req_stall, one bus access per transfer (read, write
// or ROM load); each gives exactly one response on rsp/rsp_valid/rsp_stall carrying the
// byte read and a status code. Configuration registers sit on an APB-style port at byte
// addresses 0, 4, ... 20; pready is always high and writes take effect at the access edge.
// One access is taken per cycle while req_stall is low; its response is valid the cycle
// after the transfer. All RAM regions live in one single-port synchronous RAM and ROM in
// a second one; each access is at most one read or write of one of them, whose registered
// read output feeds the response. A write is done at the request edge, so a read that
// follows it sees the byte. Reset clears the config registers and starts a clearing pass
// that writes zero through every RAM entry, one entry a cycle; requests are stalled until
// it ends, config writes are taken throughout. ROM is not cleared.
// While the receiver stalls a response, it holds and req_stall is raised.
module banked_memory_map_bus
	import bmm_pkg::*;
#(
	parameter int MAX_ROM_BANKS = 8,
	parameter int MAX_RAM_BANKS = 4
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        req_valid,
	output logic        req_stall,
	input  req_t        req,
	output logic        rsp_valid,
	input  logic        rsp_stall,
	output rsp_t        rsp,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [4:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	localparam int ROM_DEPTH = (MAX_ROM_BANKS + 1) * ROM_BANK_SIZE;
	localparam int ROM_AW    = $clog2(ROM_DEPTH);
	localparam int RAM_DEPTH = MAX_RAM_BANKS * RAM_BANK_SIZE + 2 * RAM_BANK_SIZE + SMALL_SIZE;
	localparam int RAM_AW    = $clog2(RAM_DEPTH);

	cfg_t              cfg_q;
	dec_t              ctl;
	logic [RAM_AW-1:0] dec_ram_addr;
	logic [ROM_AW-1:0] dec_rom_addr;
	logic              req_fire;
	logic              cfg_wr;
	logic [2:0]        reg_idx;

	logic              clr_busy_q;
	logic [RAM_AW-1:0] clr_addr_q;

	logic [7:0]        ram_mem [RAM_DEPTH];
	logic [7:0]        rom_mem [ROM_DEPTH];
	logic [RAM_AW-1:0] ram_addr;
	logic              ram_we;
	logic              ram_re;
	logic [7:0]        ram_wd;
	logic [7:0]        ram_rd_s1;
	logic [7:0]        rom_rd_s1;

	logic              valid_s1;
	logic              wr_s1;
	logic              from_rom_s1;
	logic [2:0]        status_s1;

	bmm_decode #(
		.MAX_ROM_BANKS(MAX_ROM_BANKS),
		.MAX_RAM_BANKS(MAX_RAM_BANKS)
	) u_decode (
		.req     (req),
		.cfg     (cfg_q),
		.ctl     (ctl),
		.ram_addr(dec_ram_addr),
		.rom_addr(dec_rom_addr)
	);

	assign req_stall = clr_busy_q || (valid_s1 && rsp_stall);
	assign req_fire  = req_valid && !req_stall;

	// Config port
	assign pready  = 1'b1;
	assign reg_idx = paddr[4:2];
	assign cfg_wr  = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_wr) begin
			unique case (reg_idx)
				REG_ROM_SEL:   cfg_q.rom_bank_select     <= pwdata[7:0];
				REG_ROM_COUNT: cfg_q.rom_bank_count      <= pwdata[3:0];
				REG_RAM_SEL:   cfg_q.ram_bank_select     <= pwdata[3:0];
				REG_RAM_COUNT: cfg_q.ram_bank_count      <= pwdata[2:0];
				REG_VRAM_LOCK: cfg_q.video_ram_locked    <= pwdata[0];
				REG_OAM_LOCK:  cfg_q.sprite_table_locked <= pwdata[0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			REG_ROM_SEL:   prdata = {24'd0, cfg_q.rom_bank_select};
			REG_ROM_COUNT: prdata = {28'd0, cfg_q.rom_bank_count};
			REG_RAM_SEL:   prdata = {28'd0, cfg_q.ram_bank_select};
			REG_RAM_COUNT: prdata = {29'd0, cfg_q.ram_bank_count};
			REG_VRAM_LOCK: prdata = {31'd0, cfg_q.video_ram_locked};
			REG_OAM_LOCK:  prdata = {31'd0, cfg_q.sprite_table_locked};
			default:       prdata = '0;
		endcase
	end

	// Clearing pass over the RAM after reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_busy_q <= 1'b1;
			clr_addr_q <= '0;
		end else if (clr_busy_q) begin
			if (clr_addr_q == RAM_AW'(RAM_DEPTH - 1))
				clr_busy_q <= 1'b0;
			clr_addr_q <= clr_addr_q + 1'b1;
		end
	end

	// RAM port select: clearing pass or request
	always_comb begin
		ram_addr = clr_busy_q ? clr_addr_q : dec_ram_addr;
		ram_we   = clr_busy_q || (req_fire && ctl.ram_en && ctl.we);
		ram_re   = req_fire && ctl.ram_en && !ctl.we;
		ram_wd   = clr_busy_q ? 8'd0 : req.write_data;
	end

	always_ff @(posedge clk) begin
		if (ram_we)
			ram_mem[ram_addr] <= ram_wd;
		if (ram_re)
			ram_rd_s1 <= ram_mem[ram_addr];
	end

	// ROM: loads write, reads are registered
	always_ff @(posedge clk) begin
		if (req_fire && ctl.rom_en && ctl.we)
			rom_mem[dec_rom_addr] <= req.write_data;
		if (req_fire && ctl.rom_en && !ctl.we)
			rom_rd_s1 <= rom_mem[dec_rom_addr];
	end

	// Response stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else if (req_fire)
			valid_s1 <= 1'b1;
		else if (!rsp_stall)
			valid_s1 <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (req_fire) begin
			wr_s1       <= ctl.we;
			from_rom_s1 <= ctl.rom_en;
			status_s1   <= ctl.status;
		end
	end

	assign rsp_valid = valid_s1;

	always_comb begin
		rsp.status = status_s1;
		if (wr_s1)
			rsp.read_data = 8'd0;
		else if (status_s1 != ST_OK)
			rsp.read_data = 8'hFF;
		else if (from_rom_s1)
			rsp.read_data = rom_rd_s1;
		else
			rsp.read_data = ram_rd_s1;
	end

	// Checks
	a_write_reads_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && wr_s1 |-> rsp.read_data == 8'd0)
		else $error("write or load response carries nonzero data");

	a_fail_reads_ff: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !wr_s1 && rsp.status != ST_OK |-> rsp.read_data == 8'hFF)
		else $error("failed read does not return 0xFF");

	a_rsp_dropped: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(rsp_valid) |-> $past(!rsp_stall))
		else $error("response withdrawn while stalled");

	a_no_req_while_clearing: assert property (@(posedge clk) disable iff (!arst_n)
		clr_busy_q |=> !(ram_re && !clr_busy_q && $past(clr_addr_q) != RAM_AW'(RAM_DEPTH - 1)))
		else $error("request served before clearing pass ended");

endmodule

// ===== dv/tb_top.sv =====
// Self-checking testbench for the banked memory map bus: directed access table, then random phases.
module tb_top;
	import bmm_pkg::*;

	localparam int ROM_BANKS      = 8;
	localparam int RAM_BANKS      = 4;
	localparam int HOLD_CYCLES    = 300;
	localparam int WATCHDOG_LIMIT = 250000;
	localparam int PHASE_ITEMS    = 55;

	// Expected answer, pinned when typed straight into the table
	typedef struct packed {
		logic pinned;
		rsp_t rsp;
	} known_answer_t;

	// One row of the directed table: a register write or a bus access
	typedef struct packed {
		logic          is_reg;
		logic [2:0]    reg_idx;
		logic [7:0]    reg_val;
		req_t          acc;
		known_answer_t answer;
	} plan_row_t;

	logic        clk;
	logic        arst_n;
	logic        req_valid;
	logic        req_stall;
	req_t        req;
	logic        rsp_valid;
	logic        rsp_stall;
	rsp_t        rsp;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [4:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;

	// Predictor images of the memory map and the register file
	cfg_t       cfg = '0;
	logic [7:0] rom_img [int];
	logic [7:0] vram_img [0:8191];
	logic [7:0] xram_img [0:RAM_BANKS*RAM_BANK_SIZE-1];
	logic [7:0] wram_img [0:8191];
	logic [7:0] oam_img [0:159];
	logic [7:0] io_img [0:127];
	logic [7:0] hram_img [0:126];
	logic [7:0] ie_img;

	// Stimulus bookkeeping: ROM bytes loaded so far, recently stored addresses
	bit            rom_seen [int];
	logic [15:0]   recent_addrs [$];
	known_answer_t known_answers [$];
	rsp_t          pending_answers [$];
	plan_row_t     plan [$];
	cfg_t          phase_cfg [8];

	int failures = 0;
	int stuck_cycles = 0;
	bit calm = 1'b0;
	bit squeeze = 1'b0;
	bit squeeze_done = 1'b0;

	banked_memory_map_bus #(
		.MAX_ROM_BANKS(ROM_BANKS),
		.MAX_RAM_BANKS(RAM_BANKS)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.req(req),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.rsp(rsp),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// ROM image key for an address under the current banking, -1 if not reachable
	function automatic int rom_key(input logic [15:0] a);
		if (a < 16'h4000)
			return int'(a);
		if (a < 16'h8000 && cfg.rom_bank_select < cfg.rom_bank_count &&
				cfg.rom_bank_select < ROM_BANKS)
			return ROM_BANK_SIZE * (1 + int'(cfg.rom_bank_select)) + int'(a) - 'h4000;
		return -1;
	endfunction

	// Decode one bus access against the images, update them, return the answer
	function automatic rsp_t decode_access(input req_t r);
		logic [15:0] a;
		logic        wr;
		int          k;
		rsp_t        res;
		a = r.bus_address;
		wr = (r.op == OP_WRITE || r.op == OP_LOAD);
		res.read_data = 8'hFF;
		res.status = ST_OK;
		// echo window folds down onto work RAM
		if (a >= 16'hE000 && a <= 16'hFDFF)
			a = a - 16'h2000;
		if (a >= 16'hFEA0 && a <= 16'hFEFF) begin
			res.status = ST_UNMAPPED;
		end else if (a < 16'h8000) begin
			k = rom_key(a);
			if (r.op == OP_WRITE)
				res.status = ST_ROMWRITE;
			else if (k < 0)
				res.status = ST_BADBANK;
			else if (wr)
				rom_img[k] = r.write_data;
			else
				res.read_data = rom_img.exists(k) ? rom_img[k] : 8'h00;
		end else if (a < 16'hA000) begin
			if (cfg.video_ram_locked && !r.from_video)
				res.status = ST_LOCKED;
			else if (wr)
				vram_img[a - 16'h8000] = r.write_data;
			else
				res.read_data = vram_img[a - 16'h8000];
		end else if (a < 16'hC000) begin
			if (cfg.ram_bank_select >= cfg.ram_bank_count || cfg.ram_bank_select >= RAM_BANKS) begin
				res.status = ST_BADBANK;
			end else begin
				k = int'(cfg.ram_bank_select) * RAM_BANK_SIZE + int'(a) - 'hA000;
				if (wr)
					xram_img[k] = r.write_data;
				else
					res.read_data = xram_img[k];
			end
		end else if (a < 16'hE000) begin
			if (wr)
				wram_img[a - 16'hC000] = r.write_data;
			else
				res.read_data = wram_img[a - 16'hC000];
		end else if (a < 16'hFEA0) begin
			// only the sprite table is left here after the fold
			if (cfg.sprite_table_locked && !r.from_video)
				res.status = ST_LOCKED;
			else if (wr)
				oam_img[a - 16'hFE00] = r.write_data;
			else
				res.read_data = oam_img[a - 16'hFE00];
		end else if (a < 16'hFF80) begin
			if (wr)
				io_img[a - 16'hFF00] = r.write_data;
			else
				res.read_data = io_img[a - 16'hFF00];
		end else if (a < 16'hFFFF) begin
			if (wr)
				hram_img[a - 16'hFF80] = r.write_data;
			else
				res.read_data = hram_img[a - 16'hFF80];
		end else begin
			if (wr)
				ie_img = r.write_data;
			else
				res.read_data = ie_img;
		end
		if (wr)
			res.read_data = 8'h00;
		return res;
	endfunction

	// Random access; reads aim at stored bytes often, never at unloaded ROM
	function automatic req_t rand_access();
		req_t        r;
		int          pick;
		logic [15:0] a;
		pick = $urandom_range(99);
		r.op = pick < 40 ? OP_READ : pick < 72 ? OP_WRITE : pick < 90 ? OP_LOAD : OP_RSVD;
		r.write_data = 8'($urandom_range(255));
		r.from_video = 1'($urandom_range(1));
		pick = $urandom_range(99);
		if (pick < 35 && recent_addrs.size() > 0)
			a = recent_addrs[$urandom_range(recent_addrs.size() - 1)];
		else if (pick < 60)
			a = 16'hFE00 + 16'($urandom_range(511));
		else if (r.op == OP_LOAD && pick < 80)
			a = 16'($urandom_range(16'h7FFF));
		else
			a = 16'($urandom_range(16'hFFFF));
		if ((r.op == OP_READ || r.op == OP_RSVD) && rom_key(a) >= 0 && !rom_seen.exists(rom_key(a)))
			r.op = OP_LOAD;
		if (r.op == OP_WRITE || r.op == OP_LOAD) begin
			recent_addrs = {recent_addrs, a};
			if (recent_addrs.size() > 24)
				void'(recent_addrs.pop_front());
		end
		r.bus_address = a;
		return r;
	endfunction

	function automatic plan_row_t access_row(input op_t op, input logic [15:0] addr,
			input logic [7:0] data, input logic vid);
		plan_row_t row;
		row = '0;
		row.acc.op = op;
		row.acc.bus_address = addr;
		row.acc.write_data = data;
		row.acc.from_video = vid;
		return row;
	endfunction

	function automatic plan_row_t pinned_row(input op_t op, input logic [15:0] addr,
			input logic [7:0] data, input logic vid, input logic [7:0] rd, input logic [2:0] st);
		plan_row_t row;
		row = access_row(op, addr, data, vid);
		row.answer = {1'b1, rd, st};
		return row;
	endfunction

	function automatic plan_row_t reg_row(input logic [2:0] idx, input logic [7:0] val);
		plan_row_t row;
		row = '0;
		row.is_reg = 1'b1;
		row.reg_idx = idx;
		row.reg_val = val;
		return row;
	endfunction

	// Append one row to the directed table
	function automatic void add_row(input plan_row_t row);
		plan = {plan, row};
	endfunction

	// Register write: setup, access, then a read-back check while idle
	task automatic write_reg(input logic [2:0] idx, input logic [7:0] val);
		logic [31:0] want;
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= {24'h0, val};
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		case (idx)
			REG_ROM_SEL:   cfg.rom_bank_select = val;
			REG_ROM_COUNT: cfg.rom_bank_count = val[3:0];
			REG_RAM_SEL:   cfg.ram_bank_select = val[3:0];
			REG_RAM_COUNT: cfg.ram_bank_count = val[2:0];
			REG_VRAM_LOCK: cfg.video_ram_locked = val[0];
			REG_OAM_LOCK:  cfg.sprite_table_locked = val[0];
			default: ;
		endcase
		@(posedge clk);
		// address is still on the register just written
		case (idx)
			REG_ROM_SEL:   want = {24'h0, cfg.rom_bank_select};
			REG_ROM_COUNT: want = {28'h0, cfg.rom_bank_count};
			REG_RAM_SEL:   want = {28'h0, cfg.ram_bank_select};
			REG_RAM_COUNT: want = {29'h0, cfg.ram_bank_count};
			REG_VRAM_LOCK: want = {31'h0, cfg.video_ram_locked};
			REG_OAM_LOCK:  want = {31'h0, cfg.sprite_table_locked};
			default:       want = '0;
		endcase
		if (prdata !== want) begin
			$error("prdata: expected %08h, got %08h", want, prdata);
			failures++;
		end
	endtask

	// Offer one access and hold it until the transfer
	task automatic offer(input req_t r, input known_answer_t ka);
		int k;
		while (!calm && $urandom_range(99) < 18) begin
			req_valid <= 1'b0;
			@(posedge clk);
		end
		k = rom_key(r.bus_address);
		if (r.op == OP_LOAD && k >= 0)
			rom_seen[k] = 1'b1;
		known_answers = {known_answers, ka};
		req <= r;
		req_valid <= 1'b1;
		do @(posedge clk); while (req_stall);
	endtask

	// Drop valid and wait for every outstanding answer
	task automatic settle();
		req_valid <= 1'b0;
		@(posedge clk);
		while (pending_answers.size() != 0)
			@(posedge clk);
	endtask

	// Receiver: random stalls, one long hold-off to back the block up
	initial begin
		rsp_stall <= 1'b0;
		forever begin
			@(posedge clk);
			if (squeeze && !squeeze_done) begin
				squeeze_done = 1'b1;
				rsp_stall <= 1'b1;
				repeat (HOLD_CYCLES) @(posedge clk);
			end
			rsp_stall <= !calm && $urandom_range(99) < 18;
		end
	end

	// Predict on each request transfer, compare on each response transfer
	always @(posedge clk) begin : scoreboard
		known_answer_t ka;
		rsp_t          want;
		if (req_valid && !req_stall) begin
			ka = known_answers.pop_front();
			want = decode_access(req);
			pending_answers = {pending_answers, (ka.pinned ? ka.rsp : want)};
		end
		if (rsp_valid && !rsp_stall) begin
			if (pending_answers.size() == 0) begin
				$error("response with nothing outstanding: read_data %02h status %0d",
					rsp.read_data, rsp.status);
				failures++;
			end else begin
				want = pending_answers.pop_front();
				if (rsp.read_data !== want.read_data) begin
					$error("read_data: expected %02h, got %02h", want.read_data, rsp.read_data);
					failures++;
				end
				if (rsp.status !== want.status) begin
					$error("status: expected %0d, got %0d", want.status, rsp.status);
					failures++;
				end
			end
		end
	end

	// Watchdog on cycles without any transfer
	always @(posedge clk) begin
		if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
			stuck_cycles <= 0;
		else
			stuck_cycles <= stuck_cycles + 1;
		if (stuck_cycles >= WATCHDOG_LIMIT) begin
			$display("CHECKS FAILED");
			$finish;
		end
	end

	initial begin
		int ph;
		arst_n <= 1'b0;
		req_valid <= 1'b0;
		req <= '0;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= '0;
		pwdata <= '0;
		foreach (vram_img[i]) vram_img[i] = 8'h00;
		foreach (xram_img[i]) xram_img[i] = 8'h00;
		foreach (wram_img[i]) wram_img[i] = 8'h00;
		foreach (oam_img[i]) oam_img[i] = 8'h00;
		foreach (io_img[i]) io_img[i] = 8'h00;
		foreach (hram_img[i]) hram_img[i] = 8'h00;
		ie_img = 8'h00;

		// Reset values, unmapped hole, ROM writes and empty banks
		add_row(pinned_row(OP_READ, 16'hC000, 8'h00, 1'b0, 8'h00, ST_OK));
		add_row(pinned_row(OP_READ, 16'hFFFF, 8'h00, 1'b0, 8'h00, ST_OK));
		add_row(pinned_row(OP_READ, 16'hFEA0, 8'h00, 1'b0, 8'hFF, ST_UNMAPPED));
		add_row(pinned_row(OP_WRITE, 16'hFEFF, 8'h5A, 1'b1, 8'h00, ST_UNMAPPED));
		add_row(pinned_row(OP_WRITE, 16'h0000, 8'hFF, 1'b0, 8'h00, ST_ROMWRITE));
		add_row(pinned_row(OP_WRITE, 16'h7FFF, 8'h00, 1'b0, 8'h00, ST_ROMWRITE));
		add_row(pinned_row(OP_LOAD, 16'h0000, 8'hA5, 1'b0, 8'h00, ST_OK));
		add_row(pinned_row(OP_LOAD, 16'h4000, 8'h11, 1'b0, 8'h00, ST_BADBANK));
		add_row(pinned_row(OP_READ, 16'hA000, 8'h00, 1'b0, 8'hFF, ST_BADBANK));
		add_row(pinned_row(OP_WRITE, 16'hBFFF, 8'h77, 1'b0, 8'h00, ST_BADBANK));
		// top banks selected, both locks on
		add_row(reg_row(REG_ROM_COUNT, 8'd8));
		add_row(reg_row(REG_ROM_SEL, 8'd7));
		add_row(reg_row(REG_RAM_COUNT, 8'd4));
		add_row(reg_row(REG_RAM_SEL, 8'd3));
		add_row(reg_row(REG_VRAM_LOCK, 8'd1));
		add_row(reg_row(REG_OAM_LOCK, 8'd1));
		add_row(pinned_row(OP_LOAD, 16'h7FFF, 8'hFF, 1'b0, 8'h00, ST_OK));
		add_row(access_row(OP_READ, 16'h7FFF, 8'h00, 1'b1));
		add_row(access_row(OP_RSVD, 16'h0000, 8'hFF, 1'b0));
		add_row(pinned_row(OP_READ, 16'h8000, 8'h00, 1'b0, 8'hFF, ST_LOCKED));
		add_row(pinned_row(OP_WRITE, 16'hFE9F, 8'h12, 1'b0, 8'h00, ST_LOCKED));
		// video unit gets past the locks
		add_row(access_row(OP_WRITE, 16'h9FFF, 8'h3C, 1'b1));
		add_row(access_row(OP_READ, 16'h9FFF, 8'h00, 1'b1));
		add_row(access_row(OP_WRITE, 16'hFE00, 8'h77, 1'b1));
		add_row(access_row(OP_READ, 16'hFE00, 8'h00, 1'b1));
		// load outside ROM stores like a write; echo top end
		add_row(access_row(OP_LOAD, 16'hFDFF, 8'h42, 1'b0));
		add_row(access_row(OP_READ, 16'hDDFF, 8'h00, 1'b0));
		add_row(access_row(OP_WRITE, 16'hBFFF, 8'h99, 1'b0));
		add_row(access_row(OP_READ, 16'hBFFF, 8'h00, 1'b0));
		add_row(access_row(OP_LOAD, 16'hFFFF, 8'hFE, 1'b0));
		add_row(access_row(OP_READ, 16'hFFFF, 8'h00, 1'b0));

		// rom sel, rom count, ram sel, ram count, video lock, sprite lock
		phase_cfg[0] = '{8'd0,   4'd8,  4'd0,  3'd4, 1'b0, 1'b0};
		phase_cfg[1] = '{8'd7,   4'd8,  4'd3,  3'd4, 1'b1, 1'b0};
		phase_cfg[2] = '{8'd255, 4'd15, 4'd15, 3'd7, 1'b1, 1'b1};
		phase_cfg[3] = '{8'd3,   4'd4,  4'd1,  3'd2, 1'b0, 1'b1};
		phase_cfg[4] = '{8'd4,   4'd4,  4'd2,  3'd2, 1'b0, 1'b0};
		phase_cfg[5] = '{8'd0,   4'd0,  4'd0,  3'd0, 1'b1, 1'b1};
		phase_cfg[6] = '{8'd5,   4'd8,  4'd2,  3'd4, 1'b0, 1'b0};
		phase_cfg[7] = '{8'd8,   4'd15, 4'd4,  3'd7, 1'b0, 1'b1};

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		// Directed table
		foreach (plan[i]) begin
			if (plan[i].is_reg) begin
				settle();
				write_reg(plan[i].reg_idx, plan[i].reg_val);
			end else begin
				offer(plan[i].acc, plan[i].answer);
			end
		end

		// Random phases, one register setting each
		for (ph = 0; ph < 8; ph++) begin
			settle();
			write_reg(REG_ROM_SEL, phase_cfg[ph].rom_bank_select);
			write_reg(REG_ROM_COUNT, {4'h0, phase_cfg[ph].rom_bank_count});
			write_reg(REG_RAM_SEL, {4'h0, phase_cfg[ph].ram_bank_select});
			write_reg(REG_RAM_COUNT, {5'h0, phase_cfg[ph].ram_bank_count});
			write_reg(REG_VRAM_LOCK, {7'h0, phase_cfg[ph].video_ram_locked});
			write_reg(REG_OAM_LOCK, {7'h0, phase_cfg[ph].sprite_table_locked});
			calm = (ph == 3);
			squeeze = (ph == 1);
			repeat (PHASE_ITEMS) offer(rand_access(), '0);
		end

		settle();
		repeat (8) @(posedge clk);
		if (failures == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule

// ===== files.f =====
rtl/core/bmm_pkg.sv
rtl/core/bmm_decode.sv
rtl/core/banked_memory_map_bus.sv
dv/tb_top.sv
